// File: sv/gss_pkg.sv
// Shared types, constants and state codes for the Gauss-Seidel solver core.
// Used by every module of the block except gss_ram; depends on nothing else.
`default_nettype none

package gss_pkg;

  // Fixed-point format and sizes
  localparam int DATA_W   = 32;
  localparam int FRAC_W   = 16;
  localparam int MAX_VARS = 16;
  localparam int ROW_W    = 4;
  localparam int COL_W    = 5;
  localparam int NVAR_W   = 5;
  localparam int ADDR_W   = 2 * ROW_W;
  localparam int ACC_W    = 64;
  localparam int MAG_W    = 62 - FRAC_W;
  localparam int DVD_W    = 62;
  localparam int DIVC_W   = 6;
  localparam int SUM_W    = 40;
  localparam int CNT_W    = 8;
  localparam int TOL_W    = 31;
  localparam int QDEPTH   = 2;

  localparam logic signed [ACC_W-1:0] ACC_LIM = (64'sd1 <<< MAG_W) - 64'sd1;
  localparam logic signed [DATA_W-1:0] DW_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] DW_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
  localparam logic [SUM_W-1:0] ONE_FIX = SUM_W'(1) << FRAC_W;

  // Register indexes of the configuration port
  localparam logic [1:0] REG_VARS = 2'd0;
  localparam logic [1:0] REG_ITER = 2'd1;
  localparam logic [1:0] REG_TOL  = 2'd2;

  localparam logic [NVAR_W-1:0] VARS_RST = NVAR_W'(16);
  localparam logic [CNT_W-1:0]  ITER_RST = CNT_W'(10);
  localparam logic [TOL_W-1:0]  TOL_RST  = TOL_W'(1);

  typedef enum logic [1:0] {
    CMD_COEF,
    CMD_RHS,
    CMD_START
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [ROW_W-1:0]   row;
    logic [ROW_W-1:0]   col;
    logic [DATA_W-1:0]  value;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_ROW,
    ST_DIAG,
    ST_RD,
    ST_MUL,
    ST_ACC,
    ST_LIMIT,
    ST_DIV,
    ST_WRITE,
    ST_EMIT
  } state_t;

endpackage

`default_nettype wire

// File: sv/gauss_seidel_solver_core.sv
// Top level of the Gauss-Seidel solver core: config registers, front, queue, back.
// Depends on gss_pkg, gss_front, gss_queue and gss_back.
//
//   channel   direction  handshake            payload
//   in        input      in_valid / in_stall  mode, row_index, col_index, element_value
//   out       output     out_valid/out_stall  var_index, solution_value, converged,
//                                             divide_fault, last
//   cfg       input      psel/penable/pwrite  paddr, pwdata, prdata
//
// A load request is consumed by the back end while it is idle. A start request runs up to
// max_iterations sweeps; each row goes through the one-bit-per-cycle divider, which is
// skipped with a zero diagonal. Results then leave at one per cycle while out_stall is low.
// Reset is synchronous and clears control state; coefficient entries stay undefined
// until written. The two-entry queue lets requests be taken while the back end is busy;
// out_stall holds the output.
`default_nettype none

module gauss_seidel_solver_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          mode,
  input  wire logic [gss_pkg::ROW_W-1:0]     row_index,
  input  wire logic [gss_pkg::COL_W-1:0]     col_index,
  input  wire logic [gss_pkg::DATA_W-1:0]    element_value,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [gss_pkg::ROW_W-1:0]          var_index,
  output logic [gss_pkg::DATA_W-1:0]         solution_value,
  output logic                               converged,
  output logic                               divide_fault,
  output logic                               last,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [3:0]                    paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  logic [gss_pkg::NVAR_W-1:0] vars_in_use;
  logic [gss_pkg::CNT_W-1:0]  max_iterations;
  logic [gss_pkg::TOL_W-1:0]  tolerance;
  logic [gss_pkg::NVAR_W-1:0] nvars;
  logic                       cfg_wr;
  logic                       q_full;
  logic                       push;
  logic                       q_pop;
  gss_pkg::cmd_t              push_cmd;
  gss_pkg::q_status_t         q_status;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      vars_in_use    <= gss_pkg::VARS_RST;
      max_iterations <= gss_pkg::ITER_RST;
      tolerance      <= gss_pkg::TOL_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        gss_pkg::REG_VARS: vars_in_use    <= pwdata[gss_pkg::NVAR_W-1:0];
        gss_pkg::REG_ITER: max_iterations <= pwdata[gss_pkg::CNT_W-1:0];
        gss_pkg::REG_TOL:  tolerance      <= pwdata[gss_pkg::TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    unique case (paddr[3:2])
      gss_pkg::REG_VARS: prdata = 32'(vars_in_use);
      gss_pkg::REG_ITER: prdata = 32'(max_iterations);
      gss_pkg::REG_TOL:  prdata = 32'(tolerance);
      default:           prdata = '0;
    endcase
  end

  // Limit the variable count to the supported range
  always_comb begin
    priority if (vars_in_use == '0) begin
      nvars = gss_pkg::NVAR_W'(1);
    end else if (vars_in_use > gss_pkg::NVAR_W'(gss_pkg::MAX_VARS)) begin
      nvars = gss_pkg::NVAR_W'(gss_pkg::MAX_VARS);
    end else begin
      nvars = vars_in_use;
    end
  end

  gss_front u_front (
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .mode          (mode),
    .row_index     (row_index),
    .col_index     (col_index),
    .element_value (element_value),
    .nvars         (nvars),
    .q_full        (q_full),
    .push          (push),
    .cmd           (push_cmd)
  );

  gss_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .full     (q_full),
    .status   (q_status)
  );

  gss_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_status       (q_status),
    .q_pop          (q_pop),
    .nvars          (nvars),
    .max_iter       (max_iterations),
    .tol            (tolerance),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .var_index      (var_index),
    .solution_value (solution_value),
    .converged      (converged),
    .divide_fault   (divide_fault),
    .last           (last)
  );

endmodule

`default_nettype wire

// File: sv/gss_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package use.
`default_nettype none

module gss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: sv/gss_front.sv
// Front end: accepts requests and classifies them into queue commands.
// Depends on gss_pkg.
`default_nettype none

module gss_front (
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          mode,
  input  wire logic [gss_pkg::ROW_W-1:0]     row_index,
  input  wire logic [gss_pkg::COL_W-1:0]     col_index,
  input  wire logic [gss_pkg::DATA_W-1:0]    element_value,
  input  wire logic [gss_pkg::NVAR_W-1:0]    nvars,
  input  wire logic                          q_full,
  output logic                               push,
  output gss_pkg::cmd_t                      cmd
);

  logic take;

  // Hold requests while the queue is full
  assign in_stall = q_full;
  assign take     = in_valid && !q_full;

  // Classify: start, coefficient, right-hand side, or drop
  always_comb begin
    cmd.row   = row_index;
    cmd.col   = col_index[gss_pkg::ROW_W-1:0];
    cmd.value = element_value;
    cmd.kind  = gss_pkg::CMD_START;
    push      = 1'b0;
    if (mode) begin
      push = take;
    end else if (col_index < nvars) begin
      cmd.kind = gss_pkg::CMD_COEF;
      push     = take;
    end else if (col_index == nvars) begin
      cmd.kind = gss_pkg::CMD_RHS;
      push     = take;
    end
  end

endmodule

`default_nettype wire

// File: sv/gss_queue.sv
// Short command queue between the front end and the solver back end.
// Depends on gss_pkg.
`default_nettype none

module gss_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  gss_pkg::cmd_t      push_cmd,
  input  wire logic          pop,
  output logic               full,
  output gss_pkg::q_status_t status
);

  gss_pkg::cmd_t entries [gss_pkg::QDEPTH];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;
  logic          do_push;
  logic          do_pop;

  assign full          = (count == 2'(gss_pkg::QDEPTH));
  assign status.valid  = (count != 2'd0);
  assign status.cmd    = entries[rd_ptr];
  assign do_push       = push && !full;
  assign do_pop        = pop && status.valid;

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop)  rd_ptr <= !rd_ptr;
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

`default_nettype wire

// File: sv/gss_div.sv
// Restoring divider, one quotient bit per cycle, unsigned magnitudes.
// Depends on gss_pkg.
`default_nettype none

module gss_div (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [gss_pkg::DVD_W-1:0]  dividend,
  input  wire logic [gss_pkg::DATA_W-1:0] divisor,
  output logic                            done,
  output logic [gss_pkg::DVD_W-1:0]       quotient
);

  logic [gss_pkg::DVD_W-1:0]  dvd;
  logic [gss_pkg::DATA_W-1:0] dsr;
  logic [gss_pkg::DATA_W-1:0] rem;
  logic [gss_pkg::DIVC_W-1:0] cnt;
  logic                       busy;
  logic [gss_pkg::DATA_W:0]   shifted;
  logic                       fits;

  assign shifted  = {rem, dvd[gss_pkg::DVD_W-1]};
  assign fits     = shifted >= {1'b0, dsr};
  assign quotient = dvd;

  // Iterate one bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dsr <= divisor;
      rem <= '0;
    end else if (busy) begin
      rem <= fits ? gss_pkg::DATA_W'(shifted - {1'b0, dsr})
                  : shifted[gss_pkg::DATA_W-1:0];
      dvd <= {dvd[gss_pkg::DVD_W-2:0], fits};
    end
  end

  // Count steps and flag completion
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == gss_pkg::DIVC_W'(gss_pkg::DVD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: sv/gss_back.sv
// Back end: runs loads and Gauss-Seidel sweeps, then streams the solution.
// Depends on gss_pkg, gss_ram and gss_div.
`default_nettype none

module gss_back (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  gss_pkg::q_status_t                 q_status,
  output logic                               q_pop,
  input  wire logic [gss_pkg::NVAR_W-1:0]    nvars,
  input  wire logic [gss_pkg::CNT_W-1:0]     max_iter,
  input  wire logic [gss_pkg::TOL_W-1:0]     tol,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [gss_pkg::ROW_W-1:0]          var_index,
  output logic [gss_pkg::DATA_W-1:0]         solution_value,
  output logic                               converged,
  output logic                               divide_fault,
  output logic                               last
);

  gss_pkg::state_t state, state_next;

  logic signed [gss_pkg::DATA_W-1:0] xv  [gss_pkg::MAX_VARS];
  logic signed [gss_pkg::DATA_W-1:0] rhs [gss_pkg::MAX_VARS];

  logic [gss_pkg::ROW_W-1:0]         row;
  logic [gss_pkg::COL_W-1:0]         col;
  logic [gss_pkg::ROW_W-1:0]         emit_idx;
  logic [gss_pkg::ROW_W-1:0]         last_idx;
  logic signed [gss_pkg::ACC_W-1:0]  acc;
  logic signed [gss_pkg::ACC_W-1:0]  prod;
  logic signed [gss_pkg::DATA_W-1:0] diag;
  logic signed [gss_pkg::DATA_W-1:0] old_x;
  logic signed [gss_pkg::DATA_W-1:0] new_x;
  logic                              quo_neg;
  logic [gss_pkg::CNT_W-1:0]         sweeps;
  logic [gss_pkg::SUM_W-1:0]         change_sum;
  logic [gss_pkg::SUM_W-1:0]         sweep_sum;
  logic                              fault;

  logic                              run_sweep;
  logic                              out_load;
  logic                              ram_we;
  logic                              div_start;
  logic [gss_pkg::ADDR_W-1:0]        ram_raddr;
  logic [gss_pkg::DATA_W-1:0]        ram_rdata;
  logic [gss_pkg::ROW_W-1:0]         x_sel;
  logic signed [gss_pkg::DATA_W-1:0] x_rd;
  logic signed [gss_pkg::ACC_W-1:0]  acc_lim;
  logic [gss_pkg::ACC_W-1:0]         acc_mag;
  logic [gss_pkg::DATA_W-1:0]        diag_mag;
  logic [gss_pkg::DVD_W-1:0]         dividend;
  logic                              div_done;
  logic [gss_pkg::DVD_W-1:0]         quotient;
  logic signed [gss_pkg::DATA_W-1:0] quo_sat;
  logic signed [gss_pkg::DATA_W:0]   delta;
  logic [gss_pkg::DATA_W:0]          delta_mag;
  logic [gss_pkg::SUM_W:0]           sum_wide;
  logic [gss_pkg::SUM_W-1:0]         sum_next;
  logic [gss_pkg::SUM_W-1:0]         conv_lim;

  assign last_idx  = gss_pkg::ROW_W'(nvars - 1'b1);
  assign run_sweep = (sweeps < max_iter) && (change_sum > gss_pkg::SUM_W'(tol));
  // Convergence bound is ten times the variable count, in fixed point
  assign conv_lim  = (gss_pkg::SUM_W'(nvars) * gss_pkg::SUM_W'(10)) << gss_pkg::FRAC_W;

  // Coefficient store
  assign ram_raddr = (state == gss_pkg::ST_ROW) ? {row, row}
                                                : {row, col[gss_pkg::ROW_W-1:0]};

  gss_ram #(
    .WIDTH (gss_pkg::DATA_W),
    .DEPTH (gss_pkg::MAX_VARS * gss_pkg::MAX_VARS)
  ) u_coeff (
    .clk   (clk),
    .we    (ram_we),
    .waddr ({q_status.cmd.row, q_status.cmd.col}),
    .wdata (q_status.cmd.value),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Single read port into the solution vector
  always_comb begin
    unique case (state)
      gss_pkg::ST_ROW: x_sel = row;
      gss_pkg::ST_MUL: x_sel = col[gss_pkg::ROW_W-1:0];
      default:         x_sel = emit_idx;
    endcase
  end
  assign x_rd = xv[x_sel];

  // Clamp the accumulator and form divider operands
  always_comb begin
    if (acc > gss_pkg::ACC_LIM) begin
      acc_lim = gss_pkg::ACC_LIM;
    end else if (acc < -gss_pkg::ACC_LIM) begin
      acc_lim = -gss_pkg::ACC_LIM;
    end else begin
      acc_lim = acc;
    end
    acc_mag  = acc_lim[gss_pkg::ACC_W-1] ? gss_pkg::ACC_W'(-acc_lim) : acc_lim;
    diag_mag = diag[gss_pkg::DATA_W-1] ? gss_pkg::DATA_W'(-diag) : diag;
    dividend = {acc_mag[gss_pkg::MAG_W-1:0], {gss_pkg::FRAC_W{1'b0}}};
  end

  gss_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (diag_mag),
    .done     (div_done),
    .quotient (quotient)
  );

  // Apply sign and saturate the quotient
  always_comb begin
    if (!quo_neg) begin
      quo_sat = (quotient > gss_pkg::DVD_W'(gss_pkg::DW_MAX)) ? gss_pkg::DW_MAX
                : gss_pkg::DATA_W'(quotient);
    end else begin
      quo_sat = (quotient > gss_pkg::DVD_W'({1'b0, gss_pkg::DW_MIN}))
                ? gss_pkg::DW_MIN : gss_pkg::DATA_W'(-quotient);
    end
  end

  // Saturating sum of absolute change
  always_comb begin
    delta     = {old_x[gss_pkg::DATA_W-1], old_x} - {new_x[gss_pkg::DATA_W-1], new_x};
    delta_mag = delta[gss_pkg::DATA_W] ? (gss_pkg::DATA_W+1)'(-delta) : delta;
    sum_wide  = {1'b0, sweep_sum} + (gss_pkg::SUM_W+1)'(delta_mag);
    sum_next  = sum_wide[gss_pkg::SUM_W] ? gss_pkg::SUM_MAX : sum_wide[gss_pkg::SUM_W-1:0];
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      gss_pkg::ST_IDLE:
        if (q_status.valid && q_status.cmd.kind == gss_pkg::CMD_START) begin
          state_next = gss_pkg::ST_CHECK;
        end
      gss_pkg::ST_CHECK: state_next = run_sweep ? gss_pkg::ST_ROW : gss_pkg::ST_EMIT;
      gss_pkg::ST_ROW:   state_next = gss_pkg::ST_DIAG;
      gss_pkg::ST_DIAG:  state_next = gss_pkg::ST_RD;
      gss_pkg::ST_RD:
        priority if (col == nvars) begin
          state_next = gss_pkg::ST_LIMIT;
        end else if (col != {1'b0, row}) begin
          state_next = gss_pkg::ST_MUL;
        end else begin
          state_next = gss_pkg::ST_RD;
        end
      gss_pkg::ST_MUL:   state_next = gss_pkg::ST_ACC;
      gss_pkg::ST_ACC:   state_next = gss_pkg::ST_RD;
      gss_pkg::ST_LIMIT: state_next = (diag == '0) ? gss_pkg::ST_WRITE : gss_pkg::ST_DIV;
      gss_pkg::ST_DIV:   if (div_done) state_next = gss_pkg::ST_WRITE;
      gss_pkg::ST_WRITE: state_next = (row == last_idx) ? gss_pkg::ST_CHECK : gss_pkg::ST_ROW;
      gss_pkg::ST_EMIT:  if (out_load && emit_idx == last_idx) state_next = gss_pkg::ST_IDLE;
      default:           state_next = gss_pkg::ST_IDLE;
    endcase
  end

  // Control strobes
  always_comb begin
    q_pop     = 1'b0;
    ram_we    = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state)
      gss_pkg::ST_IDLE: begin
        q_pop  = q_status.valid;
        ram_we = q_status.valid && q_status.cmd.kind == gss_pkg::CMD_COEF;
      end
      gss_pkg::ST_LIMIT: div_start = (diag != '0);
      gss_pkg::ST_EMIT:  out_load  = !out_valid || !out_stall;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gss_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath without reset
  always_ff @(posedge clk) begin
    if (state == gss_pkg::ST_IDLE && q_status.valid &&
        q_status.cmd.kind == gss_pkg::CMD_RHS) begin
      rhs[q_status.cmd.row] <= q_status.cmd.value;
    end
    unique case (state)
      gss_pkg::ST_CHECK: begin
        row       <= '0;
        sweep_sum <= '0;
        emit_idx  <= '0;
      end
      gss_pkg::ST_ROW: begin
        acc   <= {{(gss_pkg::ACC_W-gss_pkg::DATA_W){rhs[row][gss_pkg::DATA_W-1]}}, rhs[row]};
        old_x <= x_rd;
        col   <= '0;
      end
      gss_pkg::ST_DIAG: diag <= ram_rdata;
      gss_pkg::ST_RD:   if (col == {1'b0, row}) col <= col + 1'b1;
      gss_pkg::ST_MUL:  prod <= $signed(ram_rdata) * x_rd;
      gss_pkg::ST_ACC: begin
        acc <= acc - (prod >>> gss_pkg::FRAC_W);
        col <= col + 1'b1;
      end
      gss_pkg::ST_LIMIT: begin
        quo_neg <= acc_lim[gss_pkg::ACC_W-1] ^ diag[gss_pkg::DATA_W-1];
        if (acc_lim > 0) begin
          new_x <= gss_pkg::DW_MAX;
        end else if (acc_lim < 0) begin
          new_x <= gss_pkg::DW_MIN;
        end else begin
          new_x <= '0;
        end
      end
      gss_pkg::ST_DIV: if (div_done) new_x <= quo_sat;
      gss_pkg::ST_WRITE: begin
        sweep_sum <= sum_next;
        row       <= row + 1'b1;
      end
      gss_pkg::ST_EMIT: if (out_load) emit_idx <= emit_idx + 1'b1;
      default: ;
    endcase
  end

  // Solver state with reset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < gss_pkg::MAX_VARS; k++) xv[k] <= '0;
      sweeps     <= '0;
      change_sum <= '0;
      fault      <= 1'b0;
    end else begin
      if (state == gss_pkg::ST_IDLE && q_status.valid &&
          q_status.cmd.kind == gss_pkg::CMD_START) begin
        for (int k = 0; k < gss_pkg::MAX_VARS; k++) xv[k] <= '0;
        sweeps     <= '0;
        change_sum <= gss_pkg::ONE_FIX;
        fault      <= 1'b0;
      end
      if (state == gss_pkg::ST_LIMIT && diag == '0) begin
        fault <= 1'b1;
      end
      if (state == gss_pkg::ST_WRITE) begin
        xv[row] <= new_x;
        if (row == last_idx) begin
          change_sum <= sum_next;
          sweeps     <= sweeps + 1'b1;
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      var_index      <= emit_idx;
      solution_value <= x_rd;
      converged      <= (change_sum <= conv_lim);
      divide_fault   <= fault;
      last           <= (emit_idx == last_idx);
    end
  end

`ifndef SYNTHESIS
  a_div_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == gss_pkg::ST_DIV)
    else $error("divider finished outside the divide step");
  a_fault_clear: assert property (@(posedge clk) disable iff (rst)
    $fell(fault) |-> $past(state) == gss_pkg::ST_IDLE)
    else $error("fault flag dropped outside a start");
  a_row_range: assert property (@(posedge clk) disable iff (rst)
    state == gss_pkg::ST_WRITE |-> {1'b0, row} < nvars)
    else $error("solution row beyond variable count");
  a_emit_idle: assert property (@(posedge clk) disable iff (rst)
    out_load |-> !q_pop)
    else $error("queue popped while emitting");
`endif

endmodule

`default_nettype wire

// File: verif/gauss_seidel_solver_core_tb.sv
// Self-checking bench for gauss_seidel_solver_core: directed table, a fill-up run, random solves.
// Depends on gss_pkg and the core RTL; predicts solves in place or takes them from the table, and checks every result.
`default_nettype none

module gauss_seidel_solver_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 2000000;
  localparam longint ONE_Q = 64'sd65536;

  typedef enum logic [1:0] {OP_CFG, OP_LOAD, OP_START} dir_op_t;

  typedef struct {
    dir_op_t     op;
    logic [1:0]  reg_idx;
    logic [31:0] data;
    logic [3:0]  row;
    logic [4:0]  col;
    bit          typed;
    logic [31:0] exp_val;
    bit          exp_conv;
    bit          exp_fault;
  } dir_row_t;

  typedef struct {
    logic [3:0]  idx;
    logic [31:0] val;
    bit          conv;
    bit          fault;
    bit          is_last;
  } solution_t;

  logic clk, rst;
  logic in_valid, in_stall, mode;
  logic [gss_pkg::ROW_W-1:0] row_index;
  logic [gss_pkg::COL_W-1:0] col_index;
  logic [gss_pkg::DATA_W-1:0] element_value;
  logic out_valid, out_stall;
  logic [gss_pkg::ROW_W-1:0] var_index;
  logic [gss_pkg::DATA_W-1:0] solution_value;
  logic converged, divide_fault, last;
  logic psel, penable, pwrite, pready;
  logic [3:0] paddr;
  logic [31:0] pwdata, prdata;

  gauss_seidel_solver_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .mode(mode), .row_index(row_index),
    .col_index(col_index), .element_value(element_value),
    .out_valid(out_valid), .out_stall(out_stall), .var_index(var_index),
    .solution_value(solution_value), .converged(converged),
    .divide_fault(divide_fault), .last(last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Shadow of the block's stores and registers
  longint coef_mem[16][16];
  longint rhs_mem[16];
  int unsigned vars_cfg, iter_cfg;
  longint unsigned tol_cfg;

  solution_t expected_solutions[$];
  dir_row_t dir_table[$];
  int errors, requests_sent, solutions_seen, solves_sent;
  int send_pct, stall_pct, hold_len;
  longint unsigned cycles;

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Receiver: random stall by phase, or a long hold-off when asked
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_len > 0) begin
        out_stall <= 1'b1;
        hold_len--;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Check each accepted result against the oldest expectation
  always @(posedge clk) begin
    solution_t e;
    if (!rst && out_valid && !out_stall) begin
      solutions_seen++;
      if (expected_solutions.size() == 0) begin
        $error("unexpected result var_index=%0d", var_index);
        errors++;
      end else begin
        e = expected_solutions.pop_front();
        if (var_index !== e.idx) begin
          $error("var_index: expected %0d got %0d", e.idx, var_index); errors++;
        end
        if (solution_value !== e.val) begin
          $error("solution_value: expected %h got %h", e.val, solution_value); errors++;
        end
        if (converged !== e.conv) begin
          $error("converged: expected %0d got %0d", e.conv, converged); errors++;
        end
        if (divide_fault !== e.fault) begin
          $error("divide_fault: expected %0d got %0d", e.fault, divide_fault); errors++;
        end
        if (last !== e.is_last) begin
          $error("last: expected %0d got %0d", e.is_last, last); errors++;
        end
      end
    end
  end

  function automatic int unsigned active_n();
    if (vars_cfg == 0) return 1;
    return (vars_cfg > 16) ? 16 : vars_cfg;
  endfunction

  // Run the sweeps on the shadow stores and queue the emitted solution
  task automatic predict_solve();
    longint x[16], prev[16];
    longint acc, d, q;
    longint unsigned sum, chg;
    int unsigned n, sweeps;
    bit fault, conv;
    solution_t r;
    n = active_n();
    for (int i = 0; i < 16; i++) begin
      x[i] = 0;
      prev[i] = 0;
    end
    fault = 1'b0;
    chg = ONE_Q;
    sweeps = 0;
    while (sweeps < iter_cfg && chg > tol_cfg) begin
      for (int i = 0; i < n; i++) begin
        acc = rhs_mem[i];
        for (int j = 0; j < n; j++)
          if (j != i) acc -= (coef_mem[i][j] * x[j]) >>> gss_pkg::FRAC_W;
        if (acc > gss_pkg::ACC_LIM) acc = gss_pkg::ACC_LIM;
        if (acc < -gss_pkg::ACC_LIM) acc = -gss_pkg::ACC_LIM;
        if (coef_mem[i][i] == 0) begin
          fault = 1'b1;
          x[i] = (acc > 0) ? longint'(gss_pkg::DW_MAX)
                           : ((acc < 0) ? longint'(gss_pkg::DW_MIN) : 0);
        end else begin
          q = (acc * ONE_Q) / coef_mem[i][i];
          if (q > longint'(gss_pkg::DW_MAX)) q = longint'(gss_pkg::DW_MAX);
          if (q < longint'(gss_pkg::DW_MIN)) q = longint'(gss_pkg::DW_MIN);
          x[i] = q;
        end
      end
      sum = 0;
      for (int i = 0; i < n; i++) begin
        d = prev[i] - x[i];
        sum += (d < 0) ? -d : d;
        prev[i] = x[i];
      end
      chg = (sum > gss_pkg::SUM_MAX) ? gss_pkg::SUM_MAX : sum;
      sweeps++;
    end
    conv = !(chg > longint'(n) * 10 * ONE_Q);
    for (int i = 0; i < n; i++) begin
      r.idx = i[3:0];
      r.val = x[i][31:0];
      r.conv = conv;
      r.fault = fault;
      r.is_last = (i == n - 1);
      expected_solutions.push_back(r);
    end
  endtask

  // Offer one request, honoring the sender idle rate; valid stays up on return
  task automatic send_request(bit m, logic [3:0] r, logic [4:0] c, logic [31:0] v);
    int unsigned n;
    if ($urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_pct);
    end
    in_valid <= 1'b1;
    mode <= m;
    row_index <= r;
    col_index <= c;
    element_value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    requests_sent++;
    n = active_n();
    if (m) begin
      solves_sent++;
    end else if (c < n) begin
      coef_mem[r][c] = longint'(signed'(v));
    end else if (c == n) begin
      rhs_mem[r] = longint'(signed'(v));
    end
  endtask

  // Hold the sender until all results are back, then let the block settle
  task automatic wait_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_solutions.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    case (idx)
      gss_pkg::REG_VARS: vars_cfg = val[4:0];
      gss_pkg::REG_ITER: iter_cfg = val[7:0];
      gss_pkg::REG_TOL:  tol_cfg = val[30:0];
      default: ;
    endcase
  endtask

  // Fill every entry of the active system with random content
  task automatic load_system();
    int unsigned n;
    logic [31:0] v;
    n = active_n();
    for (int r = 0; r < n; r++)
      for (int c = 0; c <= n; c++) begin
        if ($urandom_range(7) == 0) v = $urandom;
        else if (c == n) v = $urandom;
        else if (c == r) begin
          v = ($urandom_range(9) == 0) ? 32'd0 : $urandom_range(32'h7fffffff, 32'h00040000);
          if ($urandom_range(1)) v = -v;
        end else v = $urandom_range(32'h3ffff) - 32'h20000;
        send_request(1'b0, r[3:0], c[4:0], v);
        // sprinkle in loads the block must drop
        if ($urandom_range(15) == 0)
          send_request(1'b0, 4'($urandom), 5'($urandom_range(31, n + 1)), $urandom);
      end
  endtask

  function automatic dir_row_t d_cfg(logic [1:0] idx, logic [31:0] val);
    dir_row_t t;
    t = '{OP_CFG, idx, val, 4'd0, 5'd0, 1'b0, 32'd0, 1'b0, 1'b0};
    return t;
  endfunction

  function automatic dir_row_t d_load(logic [3:0] r, logic [4:0] c, logic [31:0] val);
    dir_row_t t;
    t = '{OP_LOAD, 2'd0, val, r, c, 1'b0, 32'd0, 1'b0, 1'b0};
    return t;
  endfunction

  function automatic dir_row_t d_start(bit typed, logic [31:0] ev, bit ec, bit ef);
    dir_row_t t;
    t = '{OP_START, 2'd0, 32'd0, 4'd0, 5'd0, typed, ev, ec, ef};
    return t;
  endfunction

  // Main sequence
  initial begin
    dir_row_t t;
    solution_t r;
    int unsigned n, rand_items, mark;
    rst = 1'b1;
    in_valid = 1'b0;
    mode = 1'b0;
    row_index = '0;
    col_index = '0;
    element_value = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    errors = 0;
    requests_sent = 0;
    solutions_seen = 0;
    solves_sent = 0;
    send_pct = 0;
    stall_pct = 0;
    hold_len = 0;
    vars_cfg = gss_pkg::VARS_RST;
    iter_cfg = gss_pkg::ITER_RST;
    tol_cfg = gss_pkg::TOL_RST;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table: no sweep cases, zero diagonals, extremes, range edges
    dir_table.push_back(d_cfg(gss_pkg::REG_TOL, 32'h0001_0000));
    dir_table.push_back(d_start(1'b1, 32'd0, 1'b1, 1'b0));
    dir_table.push_back(d_cfg(gss_pkg::REG_TOL, 32'h7fff_ffff));
    dir_table.push_back(d_start(1'b1, 32'd0, 1'b1, 1'b0));
    dir_table.push_back(d_cfg(gss_pkg::REG_TOL, 32'h0000_0001));
    dir_table.push_back(d_cfg(gss_pkg::REG_ITER, 32'd0));
    dir_table.push_back(d_start(1'b1, 32'd0, 1'b1, 1'b0));
    dir_table.push_back(d_cfg(gss_pkg::REG_VARS, 32'd1));
    dir_table.push_back(d_cfg(gss_pkg::REG_ITER, 32'd1));
    dir_table.push_back(d_load(4'd0, 5'd0, 32'd0));
    dir_table.push_back(d_load(4'd0, 5'd1, 32'h0005_0000));
    dir_table.push_back(d_start(1'b1, gss_pkg::DW_MAX, 1'b0, 1'b1));
    dir_table.push_back(d_load(4'd0, 5'd1, 32'h8000_0000));
    dir_table.push_back(d_start(1'b1, gss_pkg::DW_MIN, 1'b0, 1'b1));
    dir_table.push_back(d_load(4'd0, 5'd1, 32'd0));
    dir_table.push_back(d_start(1'b1, 32'd0, 1'b1, 1'b1));
    dir_table.push_back(d_load(4'd0, 5'd0, 32'h7fff_ffff));
    dir_table.push_back(d_load(4'd0, 5'd1, 32'h7fff_ffff));
    dir_table.push_back(d_load(4'd15, 5'd31, 32'hffff_ffff));
    dir_table.push_back(d_start(1'b0, 32'd0, 1'b0, 1'b0));
    dir_table.push_back(d_cfg(gss_pkg::REG_VARS, 32'd2));
    dir_table.push_back(d_cfg(gss_pkg::REG_ITER, 32'd255));
    dir_table.push_back(d_cfg(gss_pkg::REG_TOL, 32'd0));
    dir_table.push_back(d_load(4'd0, 5'd0, 32'h0004_0000));
    dir_table.push_back(d_load(4'd0, 5'd1, 32'h0001_0000));
    dir_table.push_back(d_load(4'd1, 5'd0, 32'hffff_0000));
    dir_table.push_back(d_load(4'd1, 5'd1, 32'hfffc_0000));
    dir_table.push_back(d_load(4'd0, 5'd2, 32'h0003_0000));
    dir_table.push_back(d_load(4'd1, 5'd2, 32'h8000_0000));
    dir_table.push_back(d_start(1'b0, 32'd0, 1'b0, 1'b0));
    dir_table.push_back(d_cfg(gss_pkg::REG_VARS, 32'd0));
    dir_table.push_back(d_cfg(gss_pkg::REG_ITER, 32'd3));
    dir_table.push_back(d_start(1'b0, 32'd0, 1'b0, 1'b0));

    foreach (dir_table[k]) begin
      t = dir_table[k];
      case (t.op)
        OP_CFG: begin
          wait_drain();
          cfg_write(t.reg_idx, t.data);
        end
        OP_LOAD: send_request(1'b0, t.row, t.col, t.data);
        default: begin
          send_request(1'b1, 4'($urandom), 5'($urandom), $urandom);
          if (t.typed) begin
            n = active_n();
            for (int i = 0; i < n; i++) begin
              r = '{i[3:0], t.exp_val, t.exp_conv, t.exp_fault, (i == n - 1)};
              expected_solutions.push_back(r);
            end
          end else begin
            predict_solve();
          end
        end
      endcase
    end

    // Fill-up run: clamped full-size count, receiver held off while starts pile up
    wait_drain();
    cfg_write(gss_pkg::REG_VARS, 32'd31);
    cfg_write(gss_pkg::REG_ITER, 32'd0);
    cfg_write(gss_pkg::REG_TOL, 32'd0);
    send_request(1'b1, 4'($urandom), 5'($urandom), $urandom);
    predict_solve();
    hold_len = 20000;
    for (int k = 0; k < 4; k++) begin
      send_request(1'b0, 4'($urandom), 5'($urandom_range(31, 17)), $urandom);
      send_request(1'b1, 4'($urandom), 5'($urandom), $urandom);
      predict_solve();
    end
    wait_drain();
    cfg_write(gss_pkg::REG_VARS, 32'd16);
    send_request(1'b1, 4'($urandom), 5'($urandom), $urandom);
    predict_solve();

    // Random solves across the idling phases
    rand_items = 0;
    for (int s = 0; rand_items < 110 || s < 8; s++) begin
      wait_drain();
      case (s % 4)
        0: begin send_pct = 0;  stall_pct = 0;  end
        1: begin send_pct = 66; stall_pct = 0;  end
        2: begin send_pct = 0;  stall_pct = 66; end
        default: begin send_pct = 22; stall_pct = 22; end
      endcase
      n = ($urandom_range(5) == 0) ? $urandom_range(8, 5) : $urandom_range(4, 1);
      cfg_write(gss_pkg::REG_VARS, n);
      if (n <= 2 && $urandom_range(7) == 0) cfg_write(gss_pkg::REG_ITER, 32'd255);
      else cfg_write(gss_pkg::REG_ITER, $urandom_range(20));
      if ($urandom_range(4) == 0)
        cfg_write(gss_pkg::REG_TOL, $urandom_range(32'h7fffffff, 32'h10000));
      else cfg_write(gss_pkg::REG_TOL, $urandom_range(4096));
      mark = requests_sent;
      load_system();
      send_request(1'b1, 4'($urandom), 5'($urandom), $urandom);
      predict_solve();
      // sometimes a second start on the same system, after three overwrites
      if ($urandom_range(2) == 0) begin
        for (int k = 0; k < 3; k++)
          send_request(1'b0, 4'($urandom_range(n - 1)), 5'($urandom_range(n)), $urandom);
        send_request(1'b1, 4'($urandom), 5'($urandom), $urandom);
        predict_solve();
      end
      rand_items += requests_sent - mark;
    end

    wait_drain();
    repeat (300) @(posedge clk);
    if (expected_solutions.size() != 0) begin
      $error("%0d expected results never arrived", expected_solutions.size());
      errors++;
    end
    $display("tb: %0d requests, %0d solves, %0d results checked, %0d errors",
             requests_sent, solves_sent, solutions_seen, errors);
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

`default_nettype wire
